@@ design/alle_pkg.sv @@
// Shared widths and codes for the linked list engine.
package alle_pkg;

  localparam int KEY_IN_W = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_OUT_W = 3;

  typedef logic [STATUS_W-1:0] status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam status_t ST_INSERTED = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_DELETED = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

endpackage

@@ design/alle_ram.sv @@
// Generic single write port RAM with registered read.
module alle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/array_linked_list_engine_core.sv @@
// Top level: doubly linked list of keys kept in a fixed pool of slots.
//
// One command is taken when start is high and busy is low; each command
// gives exactly one result, shown on status and slot_index for one cycle
// with done high, and the receiver cannot stall it. Insert into an empty
// list is answered from idle without a scan. Otherwise an insert scans the
// slot valid bits one slot per cycle for the lowest free slot, then walks
// to the tail through S_LOAD, for the link memory read, and S_CHECK per
// node; a delete walks from the head through the same states per node
// visited. Busy stays high until the result is driven. Links and keys live
// in synchronous RAMs; valid bits for the links are flops cleared by reset.
module array_linked_list_engine_core #(
  parameter int SLOTS = 8,
  parameter int KEY_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               opcode,
  input  logic [alle_pkg::KEY_IN_W-1:0]      key_value,
  output logic                               busy,
  output logic                               done,
  output logic [alle_pkg::STATUS_W-1:0]      status,
  output logic [alle_pkg::SLOT_OUT_W-1:0]    slot_index
);

  localparam int IW = $clog2(SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  logic [1:0]           state;
  logic                 op;
  logic [KEY_WIDTH-1:0] key;
  logic [IW-1:0]        cur;
  logic [IW-1:0]        free_slot;
  logic [IW-1:0]        scan_idx;
  logic                 head_ok;
  logic [IW-1:0]        head_index;
  logic [SLOTS-1:0]     next_ok;
  logic [SLOTS-1:0]     prev_ok;

  logic                 accept;
  logic [KEY_WIDTH-1:0] key_in;
  logic                 key_hit;

  logic                 nxt_we;
  logic [IW-1:0]        nxt_waddr;
  logic [IW-1:0]        nxt_wdata;
  logic [IW-1:0]        nxt_rdata;
  logic                 prv_we;
  logic [IW-1:0]        prv_waddr;
  logic [IW-1:0]        prv_wdata;
  logic [IW-1:0]        prv_rdata;
  logic                 key_we;
  logic [IW-1:0]        key_waddr;
  logic [KEY_WIDTH-1:0] key_wdata;
  logic [KEY_WIDTH-1:0] key_rdata;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign key_in = KEY_WIDTH'(key_value);
  assign key_hit = (key_rdata == key);

  alle_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_next_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(cur), .rdata(nxt_rdata)
  );

  alle_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_prev_ram (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(cur), .rdata(prv_rdata)
  );

  alle_ram #(.WIDTH(KEY_WIDTH), .DEPTH(SLOTS)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(cur), .rdata(key_rdata)
  );

  always_comb begin
    nxt_we = 1'b0;
    nxt_waddr = cur;
    nxt_wdata = free_slot;
    prv_we = 1'b0;
    prv_waddr = free_slot;
    prv_wdata = cur;
    key_we = 1'b0;
    key_waddr = free_slot;
    key_wdata = key;
    if (state == S_IDLE) begin
      if (accept && opcode == alle_pkg::OP_INSERT && !head_ok) begin
        key_we = 1'b1;
        key_waddr = '0;
        key_wdata = key_in;
      end
    end else if (state == S_CHECK) begin
      if (op == alle_pkg::OP_INSERT) begin
        if (!next_ok[cur]) begin
          nxt_we = 1'b1;
          prv_we = 1'b1;
          key_we = 1'b1;
        end
      end else if (key_hit) begin
        nxt_we = prev_ok[cur];
        nxt_waddr = prv_rdata;
        nxt_wdata = nxt_rdata;
        prv_we = next_ok[cur];
        prv_waddr = nxt_rdata;
        prv_wdata = prv_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head_ok <= 1'b0;
      head_index <= '0;
      next_ok <= '0;
      prev_ok <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= opcode;
            key <= key_in;
            cur <= head_index;
            scan_idx <= '0;
            if (opcode == alle_pkg::OP_INSERT) begin
              if (!head_ok) begin
                head_ok <= 1'b1;
                head_index <= '0;
                next_ok[0] <= 1'b0;
                prev_ok[0] <= 1'b0;
                done <= 1'b1;
                status <= alle_pkg::ST_INSERTED;
                slot_index <= '0;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              if (!head_ok) begin
                done <= 1'b1;
                status <= alle_pkg::ST_NOTFOUND;
                slot_index <= '0;
              end else begin
                state <= S_LOAD;
              end
            end
          end
        end
        S_SCAN: begin
          if (scan_idx != head_index && !next_ok[scan_idx] && !prev_ok[scan_idx]) begin
            free_slot <= scan_idx;
            state <= S_LOAD;
          end else if (scan_idx == IW'(SLOTS - 1)) begin
            done <= 1'b1;
            status <= alle_pkg::ST_FULL;
            slot_index <= '0;
            state <= S_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_LOAD: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (op == alle_pkg::OP_INSERT) begin
            if (!next_ok[cur]) begin
              next_ok[cur] <= 1'b1;
              prev_ok[free_slot] <= 1'b1;
              next_ok[free_slot] <= 1'b0;
              done <= 1'b1;
              status <= alle_pkg::ST_INSERTED;
              slot_index <= alle_pkg::SLOT_OUT_W'(free_slot);
              state <= S_IDLE;
            end else begin
              cur <= nxt_rdata;
              state <= S_LOAD;
            end
          end else begin
            if (key_hit) begin
              if (prev_ok[cur]) begin
                next_ok[prv_rdata] <= next_ok[cur];
              end else begin
                head_ok <= next_ok[cur];
                head_index <= next_ok[cur] ? nxt_rdata : '0;
              end
              if (next_ok[cur]) begin
                prev_ok[nxt_rdata] <= prev_ok[cur];
              end
              prev_ok[cur] <= 1'b0;
              next_ok[cur] <= 1'b0;
              done <= 1'b1;
              status <= alle_pkg::ST_DELETED;
              slot_index <= alle_pkg::SLOT_OUT_W'(cur);
              state <= S_IDLE;
            end else if (!next_ok[cur]) begin
              done <= 1'b1;
              status <= alle_pkg::ST_NOTFOUND;
              slot_index <= '0;
              state <= S_IDLE;
            end else begin
              cur <= nxt_rdata;
              state <= S_LOAD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
